/* sv/sfc_pkg.sv */
// Shared types, constants and table functions of the scrambled frame codec.
package sfc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 32;

  localparam logic [15:0] CRC_INIT = 16'hB5D2;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  PREAMBLE = 8'h55;
  localparam logic [4:0]  FOLD_MAX = 5'd27;

  localparam logic [2:0]  ALEN_MIN   = 3'd3;
  localparam logic [2:0]  ALEN_MAX   = 3'd5;
  localparam logic [2:0]  ALEN_RESET = 3'd5;
  localparam logic [39:0] STATION_RESET = 40'hCCCCCCCCCC;

  // Configuration register indexes.
  localparam logic [1:0] REG_ALEN    = 2'd0;
  localparam logic [1:0] REG_CRC_EN  = 2'd1;
  localparam logic [1:0] REG_STATION = 2'd2;
  localparam logic [1:0] REG_DIR     = 2'd3;

  // What the current output transaction of an item carries.
  typedef enum logic [2:0] {
    K_PRE,
    K_ADDR,
    K_PAY,
    K_OVF,
    K_CRC_HI,
    K_CRC_LO
  } step_kind_t;

  typedef struct packed {
    logic [7:0] obyte;
    logic       frame_end;
    logic       overflow;
    logic       crc_feed;
  } step_res_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [2:0] eff_alen(input logic [2:0] al);
    logic [2:0] r;
    if (al < ALEN_MIN) begin
      r = ALEN_MIN;
    end else if (al > ALEN_MAX) begin
      r = ALEN_MAX;
    end else begin
      r = al;
    end
    return r;
  endfunction

  // Largest payload byte count of a frame for a given (clamped) address length.
  function automatic logic [4:0] frame_limit(input logic [2:0] al);
    logic [5:0] hl;
    logic [5:0] lim_a;
    logic [5:0] lim_b;
    hl    = {3'b000, al} + ((al == ALEN_MIN) ? 6'd1 : 6'd0);
    lim_a = 6'd30 - {3'b000, al};
    lim_b = 6'(MAX_FRAME_BYTES) - hl - 6'd2;
    return (lim_b < lim_a) ? lim_b[4:0] : lim_a[4:0];
  endfunction

  function automatic logic [7:0] whiten(input logic [5:0] idx);
    logic [7:0] w;
    case (idx)
      6'd0:  w = 8'he3;  6'd1:  w = 8'hb1;  6'd2:  w = 8'h4b;  6'd3:  w = 8'hea;
      6'd4:  w = 8'h85;  6'd5:  w = 8'hbc;  6'd6:  w = 8'he5;  6'd7:  w = 8'h66;
      6'd8:  w = 8'h0d;  6'd9:  w = 8'hae;  6'd10: w = 8'h8c;  6'd11: w = 8'h88;
      6'd12: w = 8'h12;  6'd13: w = 8'h69;  6'd14: w = 8'hee;  6'd15: w = 8'h1f;
      6'd16: w = 8'hc7;  6'd17: w = 8'h62;  6'd18: w = 8'h97;  6'd19: w = 8'hd5;
      6'd20: w = 8'h0b;  6'd21: w = 8'h79;  6'd22: w = 8'hca;  6'd23: w = 8'hcc;
      6'd24: w = 8'h1b;  6'd25: w = 8'h5d;  6'd26: w = 8'h19;  6'd27: w = 8'h10;
      6'd28: w = 8'h24;  6'd29: w = 8'hd3;  6'd30: w = 8'hdc;  6'd31: w = 8'h3f;
      6'd32: w = 8'h8e;  6'd33: w = 8'hc5;  6'd34: w = 8'h2f;
      default: w = 8'h00;
    endcase
    return w;
  endfunction

  function automatic logic [15:0] fold(input logic [4:0] idx);
    logic [15:0] f;
    case (idx)
      5'd0:  f = 16'h0000;  5'd1:  f = 16'h3448;  5'd2:  f = 16'h9BA7;
      5'd3:  f = 16'h8BBB;  5'd4:  f = 16'h85E1;  5'd5:  f = 16'h3E8C;
      5'd6:  f = 16'h451E;  5'd7:  f = 16'h18E6;  5'd8:  f = 16'h6B24;
      5'd9:  f = 16'hE7AB;  5'd10: f = 16'h3828;  5'd11: f = 16'h8148;
      5'd12: f = 16'hD461;  5'd13: f = 16'hF494;  5'd14: f = 16'h2503;
      5'd15: f = 16'h691D;  5'd16: f = 16'hFE8B;  5'd17: f = 16'h9BA7;
      5'd18: f = 16'h8B17;  5'd19: f = 16'h2920;  5'd20: f = 16'h8B5F;
      5'd21: f = 16'h61B1;  5'd22: f = 16'hD391;  5'd23: f = 16'h7401;
      5'd24: f = 16'h2138;  5'd25: f = 16'h129F;  5'd26: f = 16'hB3A0;
      5'd27: f = 16'h2988;
      default: f = 16'h0000;
    endcase
    return f;
  endfunction

endpackage

/* sv/sfc_byte_gen.sv */
// Forms the output byte and its flags for one step of the current item.
module sfc_byte_gen (
  input  sfc_pkg::step_kind_t kind,
  input  logic [2:0]          addr_idx,
  input  logic [2:0]          alen,
  input  logic [4:0]          pos,
  input  logic [15:0]         crc,
  input  logic [7:0]          data,
  input  logic                last,
  input  logic                tx,
  input  logic                crc_en,
  input  logic [39:0]         station,
  output sfc_pkg::step_res_t  res
);
  import sfc_pkg::*;

  logic [2:0]  sel;
  logic [5:0]  widx;
  logic [7:0]  wbyte;
  logic [5:0]  fidx_w;
  logic [4:0]  fidx;
  logic [15:0] fval;

  // Address bytes go out from the highest down to byte 0.
  assign sel    = alen - 3'd1 - addr_idx;
  assign widx   = {3'b000, alen} + {1'b0, pos};
  assign wbyte  = whiten(widx);
  assign fidx_w = {3'b000, alen} - 6'd3 + {1'b0, pos};
  assign fidx   = (fidx_w > {1'b0, FOLD_MAX}) ? FOLD_MAX : fidx_w[4:0];
  assign fval   = crc ^ fold(fidx);

  always_comb begin
    res = '0;
    case (kind)
      K_PRE: begin
        res.obyte = PREAMBLE;
      end
      K_ADDR: begin
        res.obyte    = station[{sel, 3'b000} +: 8] ^ whiten({3'b000, addr_idx});
        res.crc_feed = 1'b1;
      end
      K_PAY: begin
        if (tx) begin
          res.obyte     = rev8(data) ^ wbyte;
          res.crc_feed  = 1'b1;
          res.frame_end = last & ~crc_en;
        end else begin
          res.obyte     = rev8(data) ^ rev8(wbyte);
          res.frame_end = last;
        end
      end
      K_OVF: begin
        res.overflow  = 1'b1;
        res.frame_end = last & ~(tx & crc_en);
      end
      K_CRC_HI: begin
        res.obyte = fval[15:8];
      end
      K_CRC_LO: begin
        res.obyte     = fval[7:0];
        res.frame_end = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

/* sv/scrambled_rf_frame_codec_core.sv */
// Top level of the scrambled frame codec: item register, step sequencer, output register.
//
// Input channel in_*: one payload byte per transaction, in_tlast on the frame's final byte.
// Output channel out_*: one frame byte per transaction. out_tlast marks the last byte of the
// frame, out_tuser[0] the last byte caused by an input transaction, out_tuser[1] a dropped
// byte (its data reads zero).
// Configuration cfg_*: always ready; write only while no frame byte is in flight.
// In transmit mode the first payload byte of a frame expands into the optional preamble
// and the address bytes, and the final byte into payload plus, with CRC enabled, two CRC
// bytes, so one input transaction yields one to eight output transactions, one per cycle
// while the receiver is ready. Plain payload bytes and all receive-mode bytes stream at one
// transaction per cycle while the receiver is ready. From input acceptance a byte passes
// the item register, then the step logic writes the output register. The CRC advances by
// one byte per address or transmit payload step.
// A stalled receiver holds the output register; the item register then fills and in_tready
// drops. Reset empties both registers, restores the register defaults and starts a frame.
module scrambled_rf_frame_codec_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // frame_end
  output logic [1:0]  out_tuser,  // [0] run_last, [1] overflow
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data
);
  import sfc_pkg::*;

  logic [2:0]  alen_r;
  logic        crc_en_r;
  logic [39:0] station_r;
  logic        dir_r;

  logic [4:0]  pos_r;
  logic [15:0] crc_r;

  logic        item_v_r;
  logic [7:0]  data_r;
  logic        last_r;
  logic        started_r;
  step_kind_t  kind_r;
  step_kind_t  kind_nxt;
  logic [2:0]  addr_i_r;
  logic [2:0]  addr_i_nxt;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_fend_r;
  logic        out_rlast_r;
  logic        out_ovf_r;

  logic [2:0]  alen;
  logic [4:0]  lim;
  logic        tx;
  logic        crc_tail;
  step_kind_t  first_kind;
  step_kind_t  cur_kind;
  logic [2:0]  cur_i;
  logic        final_step;
  logic        out_free;
  logic        step_go;
  logic        in_acc;
  step_res_t   res;

  assign alen     = eff_alen(alen_r);
  assign lim      = frame_limit(alen);
  assign tx       = ~dir_r;
  assign crc_tail = tx & last_r & crc_en_r;

  assign out_free  = ~out_valid_r | out_tready;
  assign step_go   = item_v_r & out_free;
  assign in_tready = ~item_v_r | (out_free & final_step);
  assign in_acc    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alen_r    <= ALEN_RESET;
      crc_en_r  <= 1'b1;
      station_r <= STATION_RESET;
      dir_r     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ALEN:    alen_r    <= cfg_data[2:0];
        REG_CRC_EN:  crc_en_r  <= cfg_data[0];
        REG_STATION: station_r <= cfg_data;
        REG_DIR:     dir_r     <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // The first step of a held item is decided from the frame position it starts at.
  always_comb begin
    if (pos_r >= lim) begin
      first_kind = K_OVF;
    end else if (tx && pos_r == 5'd0) begin
      first_kind = (alen == ALEN_MIN) ? K_PRE : K_ADDR;
    end else begin
      first_kind = K_PAY;
    end
    cur_kind = started_r ? kind_r : first_kind;
    cur_i    = started_r ? addr_i_r : 3'd0;
  end

  // Next-state logic of the step sequencer.
  always_comb begin
    kind_nxt   = cur_kind;
    addr_i_nxt = cur_i;
    final_step = 1'b0;
    case (cur_kind)
      K_PRE: begin
        kind_nxt   = K_ADDR;
        addr_i_nxt = 3'd0;
      end
      K_ADDR: begin
        if (cur_i == alen - 3'd1) begin
          kind_nxt = K_PAY;
        end else begin
          addr_i_nxt = cur_i + 3'd1;
        end
      end
      K_PAY, K_OVF: begin
        kind_nxt   = K_CRC_HI;
        final_step = ~crc_tail;
      end
      K_CRC_HI: begin
        kind_nxt = K_CRC_LO;
      end
      K_CRC_LO: begin
        final_step = 1'b1;
      end
      default: begin
        final_step = 1'b1;
      end
    endcase
  end

  sfc_byte_gen u_byte_gen (
    .kind     (cur_kind),
    .addr_idx (cur_i),
    .alen     (alen),
    .pos      (pos_r),
    .crc      (crc_r),
    .data     (data_r),
    .last     (last_r),
    .tx       (tx),
    .crc_en   (crc_en_r),
    .station  (station_r),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r  <= 1'b0;
      started_r <= 1'b0;
      kind_r    <= K_PAY;
      addr_i_r  <= 3'd0;
    end else begin
      if (in_acc) begin
        item_v_r  <= 1'b1;
        started_r <= 1'b0;
      end else if (step_go) begin
        if (final_step) begin
          item_v_r  <= 1'b0;
          started_r <= 1'b0;
        end else begin
          started_r <= 1'b1;
          kind_r    <= kind_nxt;
          addr_i_r  <= addr_i_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  // Frame position and CRC; both return to their start values after the frame's last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 5'd0;
      crc_r <= CRC_INIT;
    end else if (step_go) begin
      if (final_step && last_r) begin
        pos_r <= 5'd0;
        crc_r <= CRC_INIT;
      end else begin
        if (cur_kind == K_PAY) begin
          pos_r <= pos_r + 5'd1;
        end
        if (res.crc_feed) begin
          crc_r <= crc_byte(crc_r, res.obyte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step_go;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_byte_r  <= res.obyte;
      out_fend_r  <= res.frame_end;
      out_ovf_r   <= res.overflow;
      out_rlast_r <= final_step;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_fend_r;
  assign out_tuser  = {out_ovf_r, out_rlast_r};

endmodule

/* sv/sfc_checker.sv */
// Port-level assertions for the scrambled frame codec, bound to the top level.
module sfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // Reset leaves no output transaction pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output transaction changed");

  // The end of a frame is always the final byte of its input transaction.
  a_frame_end_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("frame end without run end");

  // A dropped byte reads as zero.
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 8'h00)
    else $error("overflow byte carries data");

endmodule

bind scrambled_rf_frame_codec_core sfc_checker u_sfc_checker (.*);

/* verif/scrambled_rf_frame_codec_core_tb.sv */
// Self-checking testbench of the scrambled frame codec core: predicts and compares every frame byte.
module scrambled_rf_frame_codec_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_end;
    logic       overflow;
  } frame_byte_t;

  typedef enum logic [1:0] {
    RDY_FREE,
    RDY_COIN,
    RDY_SPARSE,
    RDY_HOLD
  } ready_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_ALEN;
  logic [39:0] cfg_data = '0;

  // Mirror of the block's registers and frame state.
  logic [2:0]  alen_r;
  logic        crc_on;
  logic [39:0] station_r;
  logic        rx_mode;
  logic [4:0]  pos_r;
  logic [15:0] crc_r;

  frame_byte_t owed_bytes[$];
  frame_byte_t due_byte;
  int          mismatch_count = 0;
  int          burst_left = 0;
  ready_mode_t ready_mode = RDY_FREE;
  int          ready_span = 0;

  logic [7:0] whiten_lut [35] = '{
    8'he3, 8'hb1, 8'h4b, 8'hea, 8'h85, 8'hbc, 8'he5, 8'h66,
    8'h0d, 8'hae, 8'h8c, 8'h88, 8'h12, 8'h69, 8'hee, 8'h1f,
    8'hc7, 8'h62, 8'h97, 8'hd5, 8'h0b, 8'h79, 8'hca, 8'hcc,
    8'h1b, 8'h5d, 8'h19, 8'h10, 8'h24, 8'hd3, 8'hdc, 8'h3f,
    8'h8e, 8'hc5, 8'h2f};

  logic [15:0] fold_lut [28] = '{
    16'h0000, 16'h3448, 16'h9BA7, 16'h8BBB, 16'h85E1, 16'h3E8C,
    16'h451E, 16'h18E6, 16'h6B24, 16'hE7AB, 16'h3828, 16'h8148,
    16'hD461, 16'hF494, 16'h2503, 16'h691D, 16'hFE8B, 16'h9BA7,
    16'h8B17, 16'h2920, 16'h8B5F, 16'h61B1, 16'hD391, 16'h7401,
    16'h2138, 16'h129F, 16'hB3A0, 16'h2988};

  scrambled_rf_frame_codec_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] flip_bits(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7 - k];
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic void restore_defaults();
    alen_r    = ALEN_RESET;
    crc_on    = 1'b1;
    station_r = STATION_RESET;
    rx_mode   = 1'b0;
    pos_r     = '0;
    crc_r     = CRC_INIT;
  endfunction

  function automatic void apply_register(input logic [1:0] idx, input logic [39:0] val);
    case (idx)
      REG_ALEN:    alen_r = val[2:0];
      REG_CRC_EN:  crc_on = val[0];
      REG_STATION: station_r = val;
      REG_DIR:     rx_mode = val[0];
      default:     ;
    endcase
  endfunction

  function automatic void owe(input logic [7:0] b, input logic fend, input logic ovf);
    frame_byte_t fb;
    fb.data      = b;
    fb.run_last  = 1'b0;
    fb.frame_end = fend;
    fb.overflow  = ovf;
    owed_bytes.push_back(fb);
  endfunction

  // The check word is the running CRC folded with a table word picked by frame size.
  function automatic void owe_check_word(input int idx);
    logic [15:0] word;
    if (idx > int'(FOLD_MAX)) begin
      idx = int'(FOLD_MAX);
    end
    word = crc_r ^ fold_lut[idx];
    owe(word[15:8], 1'b0, 1'b0);
    owe(word[7:0], 1'b1, 1'b0);
  endfunction

  // Frame bytes that one accepted payload byte should produce.
  function automatic void codec_byte_step(input logic [7:0] d, input logic last);
    int          al;
    int          hl;
    int          lim;
    int          pos;
    logic [7:0]  b;
    frame_byte_t tail;
    if (alen_r < ALEN_MIN) begin
      al = int'(ALEN_MIN);
    end else if (alen_r > ALEN_MAX) begin
      al = int'(ALEN_MAX);
    end else begin
      al = int'(alen_r);
    end
    hl  = (al == int'(ALEN_MIN)) ? al + 1 : al;
    lim = 30 - al;
    if (int'(MAX_FRAME_BYTES) - hl - 2 < lim) begin
      lim = int'(MAX_FRAME_BYTES) - hl - 2;
    end
    pos = int'(pos_r);
    if (pos >= lim) begin
      // Byte past the length limit: dropped, but a final one still closes the frame.
      if (last && !rx_mode && crc_on) begin
        owe(8'h00, 1'b0, 1'b1);
        owe_check_word(al - 3 + pos);
      end else begin
        owe(8'h00, last, 1'b1);
      end
    end else if (rx_mode) begin
      owe(flip_bits(d) ^ flip_bits(whiten_lut[al + pos]), last, 1'b0);
      pos_r = 5'(pos + 1);
    end else begin
      if (pos == 0) begin
        if (al == int'(ALEN_MIN)) begin
          owe(PREAMBLE, 1'b0, 1'b0);
        end
        for (int i = 0; i < al; i++) begin
          b = station_r[8 * (al - 1 - i) +: 8] ^ whiten_lut[i];
          crc_r = crc_update(crc_r, b);
          owe(b, 1'b0, 1'b0);
        end
      end
      b = flip_bits(d) ^ whiten_lut[al + pos];
      crc_r = crc_update(crc_r, b);
      owe(b, last && !crc_on, 1'b0);
      if (last && crc_on) begin
        owe_check_word(al - 3 + pos + 1);
      end
      pos_r = 5'(pos + 1);
    end
    if (last) begin
      pos_r = '0;
      crc_r = CRC_INIT;
    end
    tail = owed_bytes.pop_back();
    tail.run_last = 1'b1;
    owed_bytes.push_back(tail);
  endfunction

  function automatic logic [39:0] pick_value(input logic [1:0] idx);
    logic [63:0] r64;
    logic [39:0] v;
    r64 = {$urandom(), $urandom()};
    v   = '0;
    case (idx)
      REG_ALEN: begin
        v = ($urandom_range(0, 4) == 0) ? 40'(r64[2:0]) : 40'($urandom_range(3, 5));
      end
      REG_CRC_EN: begin
        v = 40'(r64[0]);
      end
      REG_STATION: begin
        case ($urandom_range(0, 5))
          0:       v = '0;
          1:       v = '1;
          default: v = r64[39:0];
        endcase
      end
      REG_DIR: begin
        v = ($urandom_range(0, 3) == 0) ? 40'd1 : 40'd0;
      end
      default: begin
        v = '0;
      end
    endcase
    return v;
  endfunction

  // Stops the sender and waits until the block has delivered every byte it owes.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (owed_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [39:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    apply_register(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Valid stays high across a burst; it only drops when a gap follows.
  task automatic send_byte(input logic [7:0] d, input logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    codec_byte_step(d, last);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic test_reset_frame();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);
  endtask

  task automatic test_preamble_address();
    cfg_write(REG_ALEN, 40'd3);
    cfg_write(REG_STATION, '1);
    send_byte(8'h81, 1'b1);
    cfg_write(REG_STATION, '0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_no_crc();
    cfg_write(REG_CRC_EN, 40'd0);
    cfg_write(REG_ALEN, 40'd4);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b1);
    cfg_write(REG_CRC_EN, 40'd1);
  endtask

  task automatic test_receive();
    cfg_write(REG_DIR, 40'd1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    cfg_write(REG_CRC_EN, 40'd0);
    send_byte(8'h3C, 1'b1);
    cfg_write(REG_CRC_EN, 40'd1);
    cfg_write(REG_DIR, 40'd0);
  endtask

  // Address lengths outside three to five act as the nearest legal length.
  task automatic test_alen_clamp();
    cfg_write(REG_ALEN, 40'd0);
    send_byte(8'hFF, 1'b1);
    cfg_write(REG_ALEN, 40'd7);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_midframe_change();
    cfg_write(REG_ALEN, 40'd4);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    cfg_write(REG_DIR, 40'd1);
    send_byte(8'h33, 1'b0);
    cfg_write(REG_STATION, pick_value(REG_STATION));
    cfg_write(REG_DIR, 40'd0);
    cfg_write(REG_ALEN, 40'd5);
    send_byte(8'h44, 1'b1);
  endtask

  // A full short-address frame, then a longer address, pushes the fold index past the table.
  task automatic test_fold_clamp();
    cfg_write(REG_ALEN, 40'd3);
    cfg_write(REG_CRC_EN, 40'd1);
    cfg_write(REG_DIR, 40'd0);
    repeat (26) send_byte(8'($urandom_range(0, 255)), 1'b0);
    cfg_write(REG_ALEN, 40'd5);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic test_random_frames(input int n_items);
    int         sent;
    int         flen;
    int         r;
    logic [1:0] idx;
    sent = 0;
    cfg_write(REG_ALEN, pick_value(REG_ALEN));
    cfg_write(REG_CRC_EN, pick_value(REG_CRC_EN));
    cfg_write(REG_STATION, pick_value(REG_STATION));
    cfg_write(REG_DIR, pick_value(REG_DIR));
    while (sent < n_items) begin
      repeat ($urandom_range(1, 3)) begin
        idx = 2'($urandom_range(0, 3));
        cfg_write(idx, pick_value(idx));
      end
      repeat ($urandom_range(2, 6)) begin
        // Mostly short frames; some run past the length limit.
        r = $urandom_range(0, 9);
        if (r < 6) begin
          flen = $urandom_range(1, 6);
        end else if (r < 8) begin
          flen = $urandom_range(7, 20);
        end else begin
          flen = $urandom_range(24, 29);
        end
        for (int k = 0; k < flen; k++) begin
          if (k != 0 && $urandom_range(0, 59) == 0) begin
            idx = 2'($urandom_range(0, 3));
            cfg_write(idx, pick_value(idx));
          end
          send_byte(8'($urandom_range(0, 255)), k == flen - 1);
        end
        sent += flen;
      end
    end
  endtask

  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_span = (ready_mode == RDY_HOLD) ? $urandom_range(1, 12) : $urandom_range(8, 64);
    end
    ready_span--;
    case (ready_mode)
      RDY_FREE:   out_tready <= 1'b1;
      RDY_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
      RDY_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
      default:    out_tready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_bytes.size() == 0) begin
        $error("out_byte: expected no transaction, got %h", out_tdata);
        mismatch_count++;
      end else begin
        due_byte = owed_bytes.pop_front();
        if (out_tdata !== due_byte.data) begin
          $error("out_byte: expected %h, got %h", due_byte.data, out_tdata);
          mismatch_count++;
        end
        if (out_tuser[0] !== due_byte.run_last) begin
          $error("run_last: expected %b, got %b", due_byte.run_last, out_tuser[0]);
          mismatch_count++;
        end
        if (out_tlast !== due_byte.frame_end) begin
          $error("frame_end: expected %b, got %b", due_byte.frame_end, out_tlast);
          mismatch_count++;
        end
        if (out_tuser[1] !== due_byte.overflow) begin
          $error("overflow: expected %b, got %b", due_byte.overflow, out_tuser[1]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    restore_defaults();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_frame();
    test_preamble_address();
    test_no_crc();
    test_receive();
    test_alen_clamp();
    test_midframe_change();
    test_fold_clamp();
    test_random_frames(300);
    settle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
sv/sfc_pkg.sv
sv/sfc_byte_gen.sv
sv/scrambled_rf_frame_codec_core.sv
sv/sfc_checker.sv
verif/scrambled_rf_frame_codec_core_tb.sv
